[rtl/core/bgrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box glyph row generator package
// Shared cell geometry, codepoint codes, command and status types, and the
// glyph decode and column mask helpers.
// ----------------------------------------------------------------------------
package bgrg_pkg;

	// cell geometry
	localparam int CELL_WIDTH  = 16;
	localparam int CELL_HEIGHT = 30;
	localparam int CX          = CELL_WIDTH / 2;
	localparam int CY          = CELL_HEIGHT / 2;
	localparam int RAD         = CELL_WIDTH / 4;

	// field and internal widths
	localparam int CP_W   = 21;
	localparam int ROW_W  = 5;
	localparam int PIX_W  = 16;
	localparam int RC_W   = $clog2(CELL_HEIGHT);
	localparam int CRD_W  = 8;
	localparam int ERR_W  = CRD_W + 2;

	typedef logic [CP_W-1:0]          cp_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [PIX_W-1:0]         pix_t;
	typedef logic [RC_W-1:0]          rcnt_t;
	typedef logic signed [CRD_W-1:0]  crd_t;
	typedef logic signed [ERR_W-1:0]  err_t;

	// light box codepoints
	localparam cp_t CP_HORZ  = 21'h02500;
	localparam cp_t CP_VERT  = 21'h02502;
	localparam cp_t CP_DR    = 21'h0250C;
	localparam cp_t CP_DL    = 21'h02510;
	localparam cp_t CP_UR    = 21'h02514;
	localparam cp_t CP_UL    = 21'h02518;
	localparam cp_t CP_VR    = 21'h0251C;
	localparam cp_t CP_VL    = 21'h02524;
	localparam cp_t CP_DH    = 21'h0252C;
	localparam cp_t CP_UH    = 21'h02534;
	localparam cp_t CP_CROSS = 21'h0253C;

	// rounded corner codepoints
	localparam cp_t CP_ARC_DR = 21'h0256D;
	localparam cp_t CP_ARC_DL = 21'h0256E;
	localparam cp_t CP_ARC_UL = 21'h0256F;
	localparam cp_t CP_ARC_UR = 21'h02570;

	// edge bit positions
	localparam int EDGE_N = 0;
	localparam int EDGE_S = 1;
	localparam int EDGE_E = 2;
	localparam int EDGE_W = 3;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic arc_step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic arc_busy;
		logic last;
	} sts_t;

	// decoded glyph: straight strokes as spans plus arc orientation
	typedef struct packed {
		logic covered;
		logic arc;
		logic right;
		logic down;
		logic h_en;
		crd_t h0;
		crd_t h1;
		logic v_en;
		crd_t v0;
		crd_t v1;
	} glyph_t;

	function automatic glyph_t glyph_decode(input cp_t cp);
		logic [3:0] e;
		glyph_t     g;
		e = '0;
		case (cp)
			CP_HORZ:  e = 4'((1 << EDGE_E) | (1 << EDGE_W));
			CP_VERT:  e = 4'((1 << EDGE_N) | (1 << EDGE_S));
			CP_DR:    e = 4'((1 << EDGE_E) | (1 << EDGE_S));
			CP_DL:    e = 4'((1 << EDGE_W) | (1 << EDGE_S));
			CP_UR:    e = 4'((1 << EDGE_E) | (1 << EDGE_N));
			CP_UL:    e = 4'((1 << EDGE_W) | (1 << EDGE_N));
			CP_VR:    e = 4'((1 << EDGE_N) | (1 << EDGE_S) | (1 << EDGE_E));
			CP_VL:    e = 4'((1 << EDGE_N) | (1 << EDGE_S) | (1 << EDGE_W));
			CP_DH:    e = 4'((1 << EDGE_E) | (1 << EDGE_W) | (1 << EDGE_S));
			CP_UH:    e = 4'((1 << EDGE_E) | (1 << EDGE_W) | (1 << EDGE_N));
			CP_CROSS: e = 4'b1111;
			default:  e = '0;
		endcase
		g.arc     = (cp >= CP_ARC_DR) && (cp <= CP_ARC_UR);
		g.right   = (cp == CP_ARC_DR) || (cp == CP_ARC_UR);
		g.down    = (cp == CP_ARC_DR) || (cp == CP_ARC_DL);
		g.covered = g.arc || (e != '0);
		if (g.arc) begin
			g.h_en = 1'b1;
			g.h0   = g.right ? crd_t'(CX + RAD) : crd_t'(0);
			g.h1   = g.right ? crd_t'(CELL_WIDTH - 1) : crd_t'(CX - RAD);
			g.v_en = 1'b1;
			g.v0   = g.down ? crd_t'(CY + RAD) : crd_t'(0);
			g.v1   = g.down ? crd_t'(CELL_HEIGHT - 1) : crd_t'(CY - RAD);
		end else begin
			g.h_en = e[EDGE_W] | e[EDGE_E];
			g.h0   = e[EDGE_W] ? crd_t'(0) : crd_t'(CX);
			g.h1   = e[EDGE_E] ? crd_t'(CELL_WIDTH - 1) : crd_t'(CX);
			g.v_en = e[EDGE_N] | e[EDGE_S];
			g.v0   = e[EDGE_N] ? crd_t'(0) : crd_t'(CY);
			g.v1   = e[EDGE_S] ? crd_t'(CELL_HEIGHT - 1) : crd_t'(CY);
		end
		return g;
	endfunction

	// single column, clipped to the cell
	function automatic pix_t col_one(input crd_t x);
		pix_t m;
		for (int c = 0; c < PIX_W; c++) begin
			m[c] = (c < CELL_WIDTH) && (x == crd_t'(c));
		end
		return m;
	endfunction

	// columns x-1 and x, clipped to the cell
	function automatic pix_t col_pair(input crd_t x);
		pix_t m;
		for (int c = 0; c < PIX_W; c++) begin
			m[c] = (c < CELL_WIDTH) && ((x == crd_t'(c)) || (x == crd_t'(c + 1)));
		end
		return m;
	endfunction

	// inclusive column span, clipped to the cell
	function automatic pix_t col_span(input crd_t lo, input crd_t hi);
		pix_t m;
		for (int c = 0; c < PIX_W; c++) begin
			m[c] = (c < CELL_WIDTH) && (crd_t'(c) >= lo) && (crd_t'(c) <= hi);
		end
		return m;
	endfunction

	// straight strokes and arc end pixels for one row
	function automatic pix_t line_row(input glyph_t g, input crd_t y);
		pix_t m;
		crd_t acx;
		crd_t acy;
		m   = '0;
		acx = g.right ? crd_t'(CX + RAD) : crd_t'(CX - RAD);
		acy = g.down ? crd_t'(CY + RAD) : crd_t'(CY - RAD);
		if (g.h_en && ((y == crd_t'(CY)) || (y == crd_t'(CY - 1))))
			m = m | col_span(g.h0, g.h1);
		if (g.v_en && (y >= g.v0) && (y <= g.v1))
			m = m | col_pair(crd_t'(CX));
		if (g.arc && (y == crd_t'(CY - 1)))
			m = m | col_one(acx);
		if (g.arc && (y == acy))
			m = m | col_one(crd_t'(CX - 1));
		return m;
	endfunction

endpackage

[rtl/core/bgrg_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box glyph row generator datapath
// Holds the cell bitmap, the midpoint arc stepper, the row counter and the
// output word register.
// ----------------------------------------------------------------------------
module bgrg_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  bgrg_pkg::cp_t     codepoint,
	input  bgrg_pkg::cmd_t    cmd,
	output bgrg_pkg::sts_t    sts,
	output bgrg_pkg::row_t    row_index,
	output bgrg_pkg::pix_t    row_pixels,
	output logic              covered,
	output logic              last_row
);

	bgrg_pkg::glyph_t dec;
	bgrg_pkg::glyph_t glyph_q;
	bgrg_pkg::pix_t   bitmap_q [bgrg_pkg::CELL_HEIGHT];
	bgrg_pkg::pix_t   arc_mask [bgrg_pkg::CELL_HEIGHT];
	bgrg_pkg::rcnt_t  row_q;
	bgrg_pkg::crd_t   ax_q;
	bgrg_pkg::crd_t   ay_q;
	bgrg_pkg::err_t   err_q;
	bgrg_pkg::crd_t   acx;
	bgrg_pkg::crd_t   acy;
	bgrg_pkg::crd_t   p1x;
	bgrg_pkg::crd_t   p1y;
	bgrg_pkg::crd_t   p2x;
	bgrg_pkg::crd_t   p2y;
	bgrg_pkg::crd_t   ay_inc;
	bgrg_pkg::crd_t   ax_dec;
	bgrg_pkg::err_t   err_neg_n;
	bgrg_pkg::err_t   err_pos_n;
	logic             last;
	bgrg_pkg::row_t   row_index_q;
	bgrg_pkg::pix_t   row_pixels_q;
	logic             covered_q;
	logic             last_row_q;

	// decode the incoming codepoint
	assign dec = bgrg_pkg::glyph_decode(codepoint);

	// arc centre and the two mirrored points of this step
	always_comb begin
		acx = glyph_q.right ? bgrg_pkg::crd_t'(bgrg_pkg::CX + bgrg_pkg::RAD)
		                    : bgrg_pkg::crd_t'(bgrg_pkg::CX - bgrg_pkg::RAD);
		acy = glyph_q.down  ? bgrg_pkg::crd_t'(bgrg_pkg::CY + bgrg_pkg::RAD)
		                    : bgrg_pkg::crd_t'(bgrg_pkg::CY - bgrg_pkg::RAD);
		p1x = glyph_q.right ? acx - ax_q : acx + ax_q;
		p1y = glyph_q.down  ? acy - ay_q : acy + ay_q;
		p2x = glyph_q.right ? acx - ay_q : acx + ay_q;
		p2y = glyph_q.down  ? acy - ax_q : acy + ax_q;
	end

	// 2x2 blocks reach up-left of each point: rows py-1 and py
	always_comb begin
		for (int y = 0; y < bgrg_pkg::CELL_HEIGHT; y++) begin
			arc_mask[y] = '0;
			if ((p1y == bgrg_pkg::crd_t'(y)) || (p1y == bgrg_pkg::crd_t'(y + 1)))
				arc_mask[y] = arc_mask[y] | bgrg_pkg::col_pair(p1x);
			if ((p2y == bgrg_pkg::crd_t'(y)) || (p2y == bgrg_pkg::crd_t'(y + 1)))
				arc_mask[y] = arc_mask[y] | bgrg_pkg::col_pair(p2x);
		end
	end

	// midpoint error update
	always_comb begin
		ay_inc    = ay_q + bgrg_pkg::crd_t'(1);
		ax_dec    = ax_q - bgrg_pkg::crd_t'(1);
		err_neg_n = err_q + (bgrg_pkg::err_t'(ay_inc) <<< 1) + bgrg_pkg::err_t'(1);
		err_pos_n = err_q + (bgrg_pkg::err_t'(ay_inc) <<< 1)
		          - (bgrg_pkg::err_t'(ax_dec) <<< 1) + bgrg_pkg::err_t'(1);
	end

	assign last = !glyph_q.covered ||
	              (row_q == bgrg_pkg::rcnt_t'(bgrg_pkg::CELL_HEIGHT - 1));

	assign sts.arc_busy = glyph_q.arc && (ax_q >= ay_q);
	assign sts.last     = last;

	// glyph, arc stepper and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_q <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			err_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cmd.load) begin
				glyph_q <= dec;
				ax_q    <= bgrg_pkg::crd_t'(bgrg_pkg::RAD);
				ay_q    <= '0;
				err_q   <= bgrg_pkg::err_t'(1 - bgrg_pkg::RAD);
				row_q   <= '0;
			end else begin
				if (cmd.arc_step) begin
					ay_q <= ay_inc;
					if (err_q < 0) begin
						err_q <= err_neg_n;
					end else begin
						ax_q  <= ax_dec;
						err_q <= err_pos_n;
					end
				end
				if (cmd.emit && !last)
					row_q <= row_q + bgrg_pkg::rcnt_t'(1);
			end
		end
	end

	// clear and draw strokes on load, merge arc blocks on each step
	always_ff @(posedge clk) begin
		for (int y = 0; y < bgrg_pkg::CELL_HEIGHT; y++) begin
			if (cmd.load)
				bitmap_q[y] <= bgrg_pkg::line_row(dec, bgrg_pkg::crd_t'(y));
			else if (cmd.arc_step)
				bitmap_q[y] <= bitmap_q[y] | arc_mask[y];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_index_q  <= bgrg_pkg::row_t'(row_q);
			row_pixels_q <= glyph_q.covered ? bitmap_q[row_q] : '0;
			covered_q    <= glyph_q.covered;
			last_row_q   <= last;
		end
	end

	assign row_index  = row_index_q;
	assign row_pixels = row_pixels_q;
	assign covered    = covered_q;
	assign last_row   = last_row_q;

endmodule

[rtl/core/bgrg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box glyph row generator controller
// Sequences load, arc stepping and row emission, and owns both handshakes.
// ----------------------------------------------------------------------------
module bgrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  bgrg_pkg::sts_t    sts,
	output bgrg_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ARC  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// commands
	assign cmd.load     = (state_q == ST_IDLE) && in_valid;
	assign cmd.arc_step = (state_q == ST_ARC) && sts.arc_busy;
	assign cmd.emit     = (state_q == ST_EMIT) && out_free;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_n = ST_ARC;
			end
			ST_ARC: begin
				if (!sts.arc_busy)
					state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && sts.last)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// hold state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/box_glyph_row_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box glyph row generator
// Draws light box and rounded corner glyphs into a 16x30 cell bitmap and
// streams it out one row word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / codepoint. A word is taken at an
//   edge with in_valid high and in_stall low; in_stall stays high until the
//   last row word of the glyph has been loaded into the output register.
//   Output channel: out_valid / out_stall / row_index, row_pixels, covered,
//   last_row. A covered glyph gives 30 row words, top row first, last_row on
//   row 29; any other codepoint gives one blank word with covered low.
//   Arc phase: every codepoint passes through it before its first row word;
//   a rounded corner makes four midpoint arc steps there through the shared
//   stepper, and a box glyph or uncovered codepoint leaves it without a step.
//   Throughput: one row word per cycle from the output register while the
//   output is not stalled.
//   A stall on the output holds the current word and pauses row emission.
//   Reset returns the controller to idle with no output word pending.
// ----------------------------------------------------------------------------
module box_glyph_row_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bgrg_pkg::cp_t       codepoint,
	output logic                out_valid,
	input  logic                out_stall,
	output bgrg_pkg::row_t      row_index,
	output bgrg_pkg::pix_t      row_pixels,
	output logic                covered,
	output logic                last_row
);

	bgrg_pkg::cmd_t cmd;
	bgrg_pkg::sts_t sts;

	bgrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bgrg_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.codepoint  (codepoint),
		.cmd        (cmd),
		.sts        (sts),
		.row_index  (row_index),
		.row_pixels (row_pixels),
		.covered    (covered),
		.last_row   (last_row)
	);

	// busy straight after taking a glyph
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous glyph still in progress");

	// never overwrite a stalled output word
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("output word overwritten under stall");

	// an uncovered codepoint yields one blank final word
	a_uncovered_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !covered |-> last_row && (row_index == '0) && (row_pixels == '0))
		else $error("uncovered word not blank and final");

	// rows never emitted while the arc is still being drawn
	a_no_emit_mid_arc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.arc_busy)
		else $error("row emitted before arc completed");

endmodule

[test/box_glyph_row_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box glyph row generator testbench
// Sends light box, rounded corner and uncovered codepoints, recomputes each
// cell bitmap locally and checks every row word the block returns, in order,
// under random gaps and stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module box_glyph_row_generator_tb;
	import bgrg_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 40;

	typedef struct packed {
		row_t idx;
		pix_t pix;
		logic cov;
		logic last;
	} row_word_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	cp_t   codepoint;
	logic  out_valid;
	logic  out_stall;
	row_t  row_index;
	pix_t  row_pixels;
	logic  covered;
	logic  last_row;

	pix_t      cell_rows [CELL_HEIGHT];
	row_word_t expected_rows [$];
	int        mismatch_count;
	int        idle_cycles;
	int        stall_mode;
	int        stall_run;
	int        long_hold_cycles;

	box_glyph_row_generator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.codepoint  (codepoint),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.row_pixels (row_pixels),
		.covered    (covered),
		.last_row   (last_row)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// light one pixel, dropping anything outside the cell
	function automatic void set_px(input int x, input int y);
		if (x >= 0 && x < CELL_WIDTH && y >= 0 && y < CELL_HEIGHT)
			cell_rows[y][x] = 1'b1;
	endfunction

	// 2x2 arc block toward up-left
	function automatic void set_blk(input int x, input int y);
		set_px(x, y);
		set_px(x - 1, y);
		set_px(x, y - 1);
		set_px(x - 1, y - 1);
	endfunction

	// paint the cell for one codepoint and queue the row words it gives
	function automatic void predict_rows(input cp_t cp);
		logic [3:0] arms;
		logic       is_arc;
		logic       right;
		logic       down;
		int         acx, acy, sx, sy, hx0, hx1, vy0, vy1, ax, ay, err;
		row_word_t  w;

		for (int y = 0; y < CELL_HEIGHT; y++)
			cell_rows[y] = '0;
		arms = '0;
		case (cp)
			CP_HORZ:  begin arms[EDGE_E] = 1'b1; arms[EDGE_W] = 1'b1; end
			CP_VERT:  begin arms[EDGE_N] = 1'b1; arms[EDGE_S] = 1'b1; end
			CP_DR:    begin arms[EDGE_E] = 1'b1; arms[EDGE_S] = 1'b1; end
			CP_DL:    begin arms[EDGE_W] = 1'b1; arms[EDGE_S] = 1'b1; end
			CP_UR:    begin arms[EDGE_E] = 1'b1; arms[EDGE_N] = 1'b1; end
			CP_UL:    begin arms[EDGE_W] = 1'b1; arms[EDGE_N] = 1'b1; end
			CP_VR:    begin
				arms[EDGE_N] = 1'b1; arms[EDGE_S] = 1'b1; arms[EDGE_E] = 1'b1;
			end
			CP_VL:    begin
				arms[EDGE_N] = 1'b1; arms[EDGE_S] = 1'b1; arms[EDGE_W] = 1'b1;
			end
			CP_DH:    begin
				arms[EDGE_E] = 1'b1; arms[EDGE_W] = 1'b1; arms[EDGE_S] = 1'b1;
			end
			CP_UH:    begin
				arms[EDGE_E] = 1'b1; arms[EDGE_W] = 1'b1; arms[EDGE_N] = 1'b1;
			end
			CP_CROSS: arms = '1;
			default:  arms = '0;
		endcase
		is_arc = (cp >= CP_ARC_DR) && (cp <= CP_ARC_UR);

		// uncovered: one blank word
		if (arms == '0 && !is_arc) begin
			w = '{idx: '0, pix: '0, cov: 1'b0, last: 1'b1};
			expected_rows.push_back(w);
			return;
		end

		if (is_arc) begin
			// rounded corner: arms, end pixels, then the midpoint arc
			right = (cp == CP_ARC_DR) || (cp == CP_ARC_UR);
			down  = (cp == CP_ARC_DR) || (cp == CP_ARC_DL);
			acx   = right ? CX + RAD : CX - RAD;
			acy   = down ? CY + RAD : CY - RAD;
			sx    = right ? -1 : 1;
			sy    = down ? -1 : 1;
			hx0   = right ? CX + RAD : 0;
			hx1   = right ? CELL_WIDTH - 1 : CX - RAD;
			vy0   = down ? CY + RAD : 0;
			vy1   = down ? CELL_HEIGHT - 1 : CY - RAD;
			for (int i = hx0; i <= hx1; i++) begin
				set_px(i, CY);
				set_px(i, CY - 1);
			end
			for (int i = vy0; i <= vy1; i++) begin
				set_px(CX, i);
				set_px(CX - 1, i);
			end
			set_px(acx, CY - 1);
			set_px(CX - 1, acy);
			ax  = RAD;
			ay  = 0;
			err = 1 - RAD;
			while (ax >= ay) begin
				set_blk(acx + sx * ax, acy + sy * ay);
				set_blk(acx + sx * ay, acy + sy * ax);
				ay++;
				if (err < 0) begin
					err += 2 * ay + 1;
				end else begin
					ax--;
					err += 2 * ay - 2 * ax + 1;
				end
			end
		end else begin
			// light box: 2-pixel strokes from each edge to the centre
			if (arms[EDGE_W])
				for (int i = 0; i <= CX; i++) begin
					set_px(i, CY);
					set_px(i, CY - 1);
				end
			if (arms[EDGE_E])
				for (int i = CX; i < CELL_WIDTH; i++) begin
					set_px(i, CY);
					set_px(i, CY - 1);
				end
			if (arms[EDGE_N])
				for (int i = 0; i <= CY; i++) begin
					set_px(CX, i);
					set_px(CX - 1, i);
				end
			if (arms[EDGE_S])
				for (int i = CY; i < CELL_HEIGHT; i++) begin
					set_px(CX, i);
					set_px(CX - 1, i);
				end
		end

		for (int y = 0; y < CELL_HEIGHT; y++) begin
			w.idx  = row_t'(y);
			w.pix  = cell_rows[y];
			w.cov  = 1'b1;
			w.last = (y == CELL_HEIGHT - 1);
			expected_rows.push_back(w);
		end
	endfunction

	// one of the fifteen drawn glyphs
	function automatic cp_t pick_glyph(input int n);
		case (n)
			0:       return CP_HORZ;
			1:       return CP_VERT;
			2:       return CP_DR;
			3:       return CP_DL;
			4:       return CP_UR;
			5:       return CP_UL;
			6:       return CP_VR;
			7:       return CP_VL;
			8:       return CP_DH;
			9:       return CP_UH;
			10:      return CP_CROSS;
			11:      return CP_ARC_DR;
			12:      return CP_ARC_DL;
			13:      return CP_ARC_UL;
			default: return CP_ARC_UR;
		endcase
	endfunction

	// offer one codepoint after a gap, hold it until taken, then predict
	task automatic send_word(input cp_t cp, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  = 1'b1;
		codepoint = cp;
		do @(posedge clk); while (in_stall);
		predict_rows(cp);
	endtask

	// stop offering and wait for every expected row word
	task automatic wait_rows_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_box_glyphs();
		stall_mode = 1;
		for (int n = 0; n <= 10; n++)
			send_word(pick_glyph(n), (n % 3 == 0) ? 0 : rand_gap());
		wait_rows_drained();
	endtask

	task automatic test_rounded_corners();
		stall_mode = 0;
		for (int n = 11; n <= 14; n++)
			send_word(pick_glyph(n), 0);
		wait_rows_drained();
	endtask

	// codepoints that draw nothing, field extremes and near misses, then a cross
	task automatic test_uncovered();
		stall_mode = 1;
		send_word(21'h000000, 0);
		send_word(21'h1FFFFF, 0);
		send_word(21'h10FFFF, rand_gap());
		send_word(21'h0024FF, 0);
		send_word(21'h002501, 0);
		send_word(21'h00253D, rand_gap());
		send_word(21'h00256C, 0);
		send_word(21'h002571, 0);
		send_word(21'h002503, 0);
		send_word(CP_CROSS, 0);
		wait_rows_drained();
	endtask

	// hold the output off while the sender keeps pushing
	task automatic test_long_hold();
		stall_mode       = 0;
		long_hold_cycles = 250;
		for (int n = 0; n < 6; n++)
			send_word((n == 2) ? 21'h000041 : pick_glyph($urandom_range(0, 14)), 0);
		wait_rows_drained();
	endtask

	// random codepoints, mostly drawn glyphs, in chunks of varying pressure
	task automatic test_random_stream();
		int   sender_mode;
		int   r;
		cp_t  cp;
		for (int chunk = 0; chunk < 11; chunk++) begin
			stall_mode  = $urandom_range(0, 2);
			sender_mode = $urandom_range(0, 1);
			for (int n = 0; n < 30; n++) begin
				r = $urandom_range(0, 9);
				if (r < 5)
					cp = pick_glyph($urandom_range(0, 14));
				else if (r < 7)
					cp = cp_t'(21'h002500 + $urandom_range(0, 127));
				else if (r < 9)
					cp = cp_t'($urandom_range(0, 21'h10FFFF));
				else
					cp = cp_t'($urandom);
				send_word(cp, sender_mode ? rand_gap() : 0);
			end
			if (chunk == 5)
				wait_rows_drained();
		end
		wait_rows_drained();
	endtask

	// output stall: random runs, plus a long hold on request
	always @(negedge clk) begin
		if (long_hold_cycles > 0) begin
			stall_run        = long_hold_cycles;
			long_hold_cycles = 0;
		end
		if (stall_run == 0 && stall_mode != 0 && $urandom_range(0, 9) < 2 * stall_mode)
			stall_run = rand_gap();
		if (stall_run > 0) begin
			out_stall = 1'b1;
			stall_run--;
		end else begin
			out_stall = 1'b0;
		end
	end

	function automatic void report_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatch_count++;
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
	endfunction

	// compare each taken row word with the oldest expectation
	always @(posedge clk) begin
		row_word_t w;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_rows.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected row word: expected none, actual row %0d pixels %h",
					$time, row_index, row_pixels);
			end else begin
				w = expected_rows.pop_front();
				if (row_index !== w.idx)
					report_field("row_index", 32'(w.idx), 32'(row_index));
				if (row_pixels !== w.pix)
					report_field("row_pixels", 32'(w.pix), 32'(row_pixels));
				if (covered !== w.cov)
					report_field("covered", 32'(w.cov), 32'(covered));
				if (last_row !== w.last)
					report_field("last_row", 32'(w.last), 32'(last_row));
			end
		end
	end

	// end the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		codepoint        = '0;
		out_stall        = 1'b0;
		mismatch_count   = 0;
		idle_cycles      = 0;
		stall_mode       = 0;
		stall_run        = 0;
		long_hold_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_box_glyphs();
		test_rounded_corners();
		test_uncovered();
		test_long_hold();
		test_random_stream();

		// let anything stray come out before judging
		stall_mode = 0;
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_rows.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
rtl/core/bgrg_pkg.sv
rtl/core/bgrg_dpath.sv
rtl/core/bgrg_ctrl.sv
rtl/core/box_glyph_row_generator.sv
test/box_glyph_row_generator_tb.sv
